// File: rtl/core/assert_macros.svh
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define SGA8_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("check failed");

// Next-cycle implication, off while reset is held.
`define SGA8_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("check failed");

`endif

// File: rtl/core/sga8_pkg.sv
`timescale 1ns / 1ps
package sga8_pkg;

    localparam int MAX_QUERY     = 64;
    localparam int ALPHABET_SIZE = 32;

    localparam int IDX_W      = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;
    localparam int LEN_W      = $clog2(MAX_QUERY + 1);
    localparam int TAB_DEPTH  = ALPHABET_SIZE * ALPHABET_SIZE;
    localparam int TAB_AW     = (TAB_DEPTH > 1) ? $clog2(TAB_DEPTH) : 1;

    localparam logic signed [7:0] SCORE_FLOOR = -8'sd128;
    localparam logic signed [7:0] SCORE_CEIL  = 8'sd127;

    localparam logic [6:0] GAP_OPEN_RST   = 7'd10;
    localparam logic [6:0] GAP_EXTEND_RST = 7'd1;

    // configuration register indexes
    localparam logic CFG_GAP_OPEN   = 1'b0;
    localparam logic CFG_GAP_EXTEND = 1'b1;

    typedef enum logic [1:0] {
        ACT_TABLE = 2'd0,
        ACT_QUERY = 2'd1,
        ACT_DB    = 2'd2,
        ACT_CLEAR = 2'd3
    } t_action;

    typedef struct packed {
        t_action           action;
        logic [4:0]        residue;
        logic [4:0]        row;
        logic signed [7:0] value;
        logic              last;
    } t_in_req;

    typedef struct packed {
        logic signed [7:0] score;
        logic              saturated;
    } t_out_req;

    // wavefront token handed from cell to cell
    typedef struct packed {
        logic              v;
        logic signed [7:0] diag;
        logic signed [7:0] up_h;
        logic signed [7:0] up_f;
        logic signed [7:0] best;
        logic              sat;
    } t_tok;

    function automatic logic signed [7:0] max8(logic signed [7:0] a, logic signed [7:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic signed [7:0] clamp10(logic signed [9:0] v);
        logic signed [7:0] r;
        if (v < -10'sd128) r = SCORE_FLOOR;
        else if (v > 10'sd127) r = SCORE_CEIL;
        else r = v[7:0];
        return r;
    endfunction

    function automatic logic signed [7:0] sat_sub(logic signed [7:0] a, logic [6:0] b);
        logic signed [9:0] d;
        d = {{2{a[7]}}, a} - $signed({3'b000, b});
        return clamp10(d);
    endfunction

    function automatic logic signed [7:0] sat_add(logic signed [7:0] a, logic signed [7:0] b);
        logic signed [9:0] s;
        s = {{2{a[7]}}, a} + {{2{b[7]}}, b};
        return clamp10(s);
    endfunction

endpackage

// File: rtl/core/semiglobal_affine_align_score8.sv
`timescale 1ns / 1ps
// Semi-global affine-gap alignment scorer, saturating 8-bit arithmetic.
// Input channel (i_in_valid / o_in_stall, payload i_in) takes four kinds of
// request: table write, query append, database residue and query clear.
// Table writes, appends and clears do not hold off the next request.
// A database residue sends one token down a row of MAX_QUERY cells, one cell
// per query row, one cell per cycle; the block takes no new request until the
// cycle after the token leaves the last cell. Ahead of the row sit two memory
// reads (query residue, then substitution score); the busy flag drops as the
// token leaves the last cell.
// A residue flagged last produces one result on o_out_valid / o_out, registered
// from the token that leaves the last cell.
// A result waits in the output register while i_out_stall is high; a second
// one parks in a skid register, and o_in_stall holds until it drains.
// Gap penalties are written over the plain port i_cfg_we / i_cfg_idx / i_cfg_data;
// the user must write them only while the block is idle; the block does not enforce it.
// Synchronous reset clears the query length, the per-row H and E state,
// the running best and the saturation flag, and restores the gap defaults.
// Table and query memories keep their contents and are undefined until written.
module semiglobal_affine_align_score8 (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  sga8_pkg::t_in_req    i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output sga8_pkg::t_out_req   o_out,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [6:0]           i_cfg_data
);

    localparam int MQ    = sga8_pkg::MAX_QUERY;
    localparam int IDX_W = sga8_pkg::IDX_W;
    localparam int LEN_W = sga8_pkg::LEN_W;
    localparam int TAB_AW = sga8_pkg::TAB_AW;

    // configuration
    logic [6:0] r_gap_open;
    logic [6:0] r_gap_ext;

    // memories
    logic signed [7:0] r_tab [sga8_pkg::TAB_DEPTH];
    logic [4:0]        r_qmem [MQ];

    // sequence state
    logic [LEN_W-1:0]  r_qlen;
    logic signed [7:0] r_best;
    logic              r_sat_seen;

    // residue in flight
    logic              r_busy;
    logic [4:0]        r_d;
    logic              r_last;
    logic              r_run;
    logic [IDX_W-1:0]  r_k;
    logic [4:0]        r_qd;
    logic              r_f1;
    logic              r_f2;
    logic signed [7:0] r_sub_raw;
    logic              r_oor;

    // output register and skid
    logic                 r_out_v;
    sga8_pkg::t_out_req   r_out;
    logic                 r_skid_v;
    sga8_pkg::t_out_req   r_skid;

    logic                 w_acc;
    logic                 w_tab_ok;
    logic [TAB_AW-1:0]    w_tab_waddr;
    logic [TAB_AW-1:0]    w_tab_raddr;
    logic                 w_oor;
    logic signed [7:0]    w_sub;
    logic                 w_exit;
    logic                 w_push;
    logic                 w_clear;
    logic                 w_slot_free;
    logic signed [7:0]    n_best;
    logic                 n_sat;
    sga8_pkg::t_out_req   n_res;

    sga8_pkg::t_tok       w_tok [MQ+1];
    logic [MQ-1:0]        w_en;

    assign o_in_stall = r_busy | r_skid_v;
    assign w_acc      = i_in_valid & ~o_in_stall;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_open <= sga8_pkg::GAP_OPEN_RST;
            r_gap_ext  <= sga8_pkg::GAP_EXTEND_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sga8_pkg::CFG_GAP_OPEN:   r_gap_open <= i_cfg_data;
                sga8_pkg::CFG_GAP_EXTEND: r_gap_ext  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // substitution table: one write port, one registered read port
    assign w_tab_ok = ({1'b0, i_in.row} < 6'(sga8_pkg::ALPHABET_SIZE)) &&
                      ({1'b0, i_in.residue} < 6'(sga8_pkg::ALPHABET_SIZE));
    assign w_tab_waddr = TAB_AW'(int'(i_in.row) * sga8_pkg::ALPHABET_SIZE
                                 + int'(i_in.residue));
    assign w_tab_raddr = TAB_AW'(int'(r_qd) * sga8_pkg::ALPHABET_SIZE + int'(r_d));
    // codes outside the alphabet score zero
    assign w_oor = ({1'b0, r_qd} >= 6'(sga8_pkg::ALPHABET_SIZE)) ||
                   ({1'b0, r_d} >= 6'(sga8_pkg::ALPHABET_SIZE));

    always_ff @(posedge i_clk) begin
        if (w_acc && i_in.action == sga8_pkg::ACT_TABLE && w_tab_ok) begin
            r_tab[w_tab_waddr] <= i_in.value;
        end
        r_sub_raw <= r_tab[w_tab_raddr];
        r_oor     <= w_oor;
    end

    assign w_sub = r_oor ? 8'sd0 : r_sub_raw;

    // query residues: append at the current length, read in row order
    always_ff @(posedge i_clk) begin
        if (w_acc && i_in.action == sga8_pkg::ACT_QUERY && r_qlen < LEN_W'(MQ)) begin
            r_qmem[r_qlen[IDX_W-1:0]] <= i_in.residue;
        end
        r_qd <= r_qmem[r_k];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_acc && i_in.action == sga8_pkg::ACT_CLEAR)) begin
            r_qlen <= '0;
        end else if (w_acc && i_in.action == sga8_pkg::ACT_QUERY && r_qlen < LEN_W'(MQ)) begin
            r_qlen <= r_qlen + LEN_W'(1);
        end
    end

    // sequencer: walk the row index ahead of the token, through the query read and
    // the table read, so the substitution score meets the token at each cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_k   <= '0;
            r_f1  <= 1'b0;
            r_f2  <= 1'b0;
        end else begin
            if (w_acc && i_in.action == sga8_pkg::ACT_DB) begin
                r_run <= 1'b1;
                r_k   <= '0;
            end else if (r_run) begin
                if (r_k == IDX_W'(MQ - 1)) begin
                    r_run <= 1'b0;
                end else begin
                    r_k <= r_k + IDX_W'(1);
                end
            end
            r_f1 <= r_run && (r_k == '0);
            r_f2 <= r_f1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && i_in.action == sga8_pkg::ACT_DB) begin
            r_d    <= i_in.residue;
            r_last <= i_in.last;
        end
    end

    // boundary token for row zero
    assign w_tok[0] = '{v:    r_f2,
                        diag: 8'sd0,
                        up_h: 8'sd0,
                        up_f: sga8_pkg::SCORE_FLOOR,
                        best: sga8_pkg::SCORE_FLOOR,
                        sat:  1'b0};

    genvar gi;
    generate
        for (gi = 0; gi < MQ; gi++) begin : g_cell
            assign w_en[gi] = (LEN_W'(gi) < r_qlen);
            sga8_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_clear    (w_clear),
                .i_en       (w_en[gi]),
                .i_sub      (w_sub),
                .i_gap_open (r_gap_open),
                .i_gap_ext  (r_gap_ext),
                .i_tok      (w_tok[gi]),
                .o_tok      (w_tok[gi+1])
            );
        end
    endgenerate

    // token leaving the last cell closes the column
    assign w_exit = w_tok[MQ].v;
    assign w_push = w_exit & r_last;

    always_comb begin
        n_best          = (r_qlen != '0) ? sga8_pkg::max8(r_best, w_tok[MQ].up_h) : r_best;
        n_sat           = r_sat_seen | w_tok[MQ].sat;
        n_res.saturated = n_sat;
        n_res.score     = n_sat ? sga8_pkg::SCORE_CEIL
                                : sga8_pkg::max8(n_best, w_tok[MQ].best);
    end

    // a finished sequence and a query clear both reset the row state
    assign w_clear = w_push | (w_acc && i_in.action == sga8_pkg::ACT_CLEAR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clear) begin
            r_best     <= sga8_pkg::SCORE_FLOOR;
            r_sat_seen <= 1'b0;
        end else if (w_exit) begin
            r_best     <= n_best;
            r_sat_seen <= n_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_acc && i_in.action == sga8_pkg::ACT_DB) begin
            r_busy <= 1'b1;
        end else if (w_exit) begin
            r_busy <= 1'b0;
        end
    end

    // output register with one skid entry; a new result cannot arrive while
    // the skid is full because the input stalls then
    assign w_slot_free = ~r_out_v | ~i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (w_slot_free) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= w_push;
            end
        end else if (w_push) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_slot_free) begin
            if (r_skid_v) begin
                r_out <= r_skid;
            end else if (w_push) begin
                r_out <= n_res;
            end
        end else if (w_push) begin
            r_skid <= n_res;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

endmodule

// File: rtl/core/sga8_cell.sv
`timescale 1ns / 1ps
module sga8_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_clear,
    input  logic                      i_en,
    input  logic signed [7:0]         i_sub,
    input  logic [6:0]                i_gap_open,
    input  logic [6:0]                i_gap_ext,
    input  sga8_pkg::t_tok            i_tok,
    output sga8_pkg::t_tok            o_tok
);

    logic signed [7:0] r_h;
    logic signed [7:0] r_e;
    sga8_pkg::t_tok    r_tok;

    logic signed [7:0] w_f;
    logic signed [7:0] w_e;
    logic signed [7:0] w_h;
    logic              w_hit;

    always_comb begin
        w_f   = sga8_pkg::max8(sga8_pkg::sat_sub(i_tok.up_h, i_gap_open),
                               sga8_pkg::sat_sub(i_tok.up_f, i_gap_ext));
        w_e   = sga8_pkg::max8(sga8_pkg::sat_sub(r_h, i_gap_open),
                               sga8_pkg::sat_sub(r_e, i_gap_ext));
        w_h   = sga8_pkg::max8(sga8_pkg::sat_add(i_tok.diag, i_sub),
                               sga8_pkg::max8(w_e, w_f));
        w_hit = (w_h == sga8_pkg::SCORE_FLOOR) || (w_h == sga8_pkg::SCORE_CEIL);
    end

    // row state: H and E of the previous column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_h <= '0;
            r_e <= sga8_pkg::SCORE_FLOOR;
        end else if (i_tok.v && i_en) begin
            r_h <= w_h;
            r_e <= w_e;
        end
    end

    // unused rows pass the token on untouched
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.v <= 1'b0;
        end else begin
            r_tok.v <= i_tok.v;
        end
        if (i_en) begin
            r_tok.diag <= r_h;
            r_tok.up_h <= w_h;
            r_tok.up_f <= w_f;
            r_tok.best <= sga8_pkg::max8(i_tok.best, w_h);
            r_tok.sat  <= i_tok.sat | w_hit;
        end else begin
            r_tok.diag <= i_tok.diag;
            r_tok.up_h <= i_tok.up_h;
            r_tok.up_f <= i_tok.up_f;
            r_tok.best <= i_tok.best;
            r_tok.sat  <= i_tok.sat;
        end
    end

    assign o_tok = r_tok;

endmodule

// File: rtl/core/sga8_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sga8_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input sga8_pkg::t_in_req    i_in,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input sga8_pkg::t_out_req   o_out,
    input logic                 i_cfg_we,
    input logic                 i_cfg_idx,
    input logic [6:0]           i_cfg_data
);

    logic w_acc;
    logic w_cfg_touch;

    assign w_acc       = i_in_valid & ~o_in_stall;
    assign w_cfg_touch = i_cfg_we & (i_cfg_idx | ~i_cfg_idx) & (i_cfg_data == i_cfg_data);

    // a database residue holds the input off while its column runs
    `SGA8_ASSERT_NEXT(a_db_stalls, i_clk, i_rst_n, w_acc && i_in.action == sga8_pkg::ACT_DB, o_in_stall)

    // other requests, with no configuration write alongside, leave the input open in the next cycle
    `SGA8_ASSERT_NEXT(a_other_open, i_clk, i_rst_n, w_acc && i_in.action != sga8_pkg::ACT_DB && !w_cfg_touch, !o_in_stall)

    // a saturated result always reports the top score
    `SGA8_ASSERT_NOW(a_sat_score, i_clk, i_rst_n, o_out_valid && o_out.saturated, o_out.score == sga8_pkg::SCORE_CEIL)

    // a stalled result holds
    `SGA8_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out))

endmodule

bind semiglobal_affine_align_score8 sga8_checker u_sga8_checker (.*);
